// ===== hdl/oas_pkg.sv =====
// oas_pkg: shared widths, operation and status codes, pointer sources and
// the command and status structs between controller and datapath
// no dependencies
package oas_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);

    localparam int OP_W  = 3;
    localparam int VAL_W = 32;
    localparam int POS_W = 7;
    localparam int CNT_W = 7;
    localparam int ST_W  = 3;

    localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
    localparam logic [OP_W-1:0] OP_SEARCH   = 3'd2;
    localparam logic [OP_W-1:0] OP_APPEND   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_FWD = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_REV = 3'd5;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

    localparam logic [1:0] PTR_ZERO   = 2'd0;
    localparam logic [1:0] PTR_CNT_M1 = 2'd1;
    localparam logic [1:0] PTR_POS    = 2'd2;

    typedef struct packed {
        logic            load;
        logic            ptr_ld;
        logic [1:0]      ptr_src;
        logic            ptr_step;
        logic            shift_rd;
        logic            put_wr;
        logic            cnt_inc;
        logic            cnt_dec;
        logic            ref_upd;
        logic            out_ld;
        logic [ST_W-1:0] out_status;
        logic            out_found;
        logic            out_data;
        logic            out_last;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            ins_bad;
        logic            del_bad;
        logic            full;
        logic            ins_tail;
        logic            del_tail;
        logic            empty;
        logic            app_refuse;
        logic            ptr_is_zero;
        logic            ptr_is_cnt_m1;
        logic            ptr_is_pos_m1;
        logic            match;
        logic            out_free;
    } t_stat;

endpackage

// ===== hdl/oas_ram.sv =====
// oas_ram: generic simple dual-port ram, one write port, one read port
// with registered read data; no dependencies
module oas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/oas_dp.sv =====
// oas_dp: datapath - item registers, element ram, fill count, batch flag,
// walk pointer and result register; uses oas_pkg and oas_ram
module oas_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  oas_pkg::t_cmd                     i_cmd,
    output oas_pkg::t_stat                    o_stat,
    input  logic [oas_pkg::OP_W-1:0]          i_operation,
    input  logic signed [oas_pkg::VAL_W-1:0]  i_value,
    input  logic [oas_pkg::POS_W-1:0]         i_position,
    input  logic                              i_batch_first,
    input  logic [oas_pkg::CNT_W-1:0]         i_batch_length,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [oas_pkg::ST_W-1:0]          o_status,
    output logic [oas_pkg::POS_W-1:0]         o_found_position,
    output logic signed [oas_pkg::VAL_W-1:0]  o_read_value,
    output logic [oas_pkg::CNT_W-1:0]         o_fill_count,
    output logic                              o_last
);

    logic [oas_pkg::OP_W-1:0]         r_op;
    logic signed [oas_pkg::VAL_W-1:0] r_val;
    logic [oas_pkg::POS_W-1:0]        r_pos;
    logic                             r_first;
    logic [oas_pkg::CNT_W-1:0]        r_blen;

    logic [oas_pkg::CNT_W-1:0]        r_count;
    logic                             r_refused;
    logic [oas_pkg::CNT_W-1:0]        r_ptr;
    logic [oas_pkg::AW-1:0]           r_wa;
    logic                             r_pend;

    logic                             r_out_valid;
    logic [oas_pkg::ST_W-1:0]         r_status;
    logic [oas_pkg::POS_W-1:0]        r_fpos;
    logic signed [oas_pkg::VAL_W-1:0] r_rdata;
    logic [oas_pkg::CNT_W-1:0]        r_fill;
    logic                             r_last;

    logic [oas_pkg::VAL_W-1:0]        rd_data;
    logic                             we;
    logic [oas_pkg::AW-1:0]           waddr;
    logic [oas_pkg::VAL_W-1:0]        wdata;
    logic [oas_pkg::CNT_W-1:0]        put_addr;
    logic [oas_pkg::CNT_W-1:0]        wa_full;
    logic [oas_pkg::CNT_W:0]          cnt_ext;
    logic [oas_pkg::CNT_W:0]          pos_ext;
    logic [oas_pkg::CNT_W:0]          batch_sum;
    logic                             ref_now;
    logic                             full;
    logic                             step_down;

    assign cnt_ext   = {1'b0, r_count};
    assign pos_ext   = {1'b0, r_pos};
    assign batch_sum = cnt_ext + {1'b0, r_blen};
    assign full      = (r_count >= oas_pkg::CNT_W'(oas_pkg::DEPTH));
    assign ref_now   = r_first ? (batch_sum > (oas_pkg::CNT_W+1)'(oas_pkg::DEPTH)) : r_refused;
    assign step_down = (r_op == oas_pkg::OP_INSERT) || (r_op == oas_pkg::OP_READ_REV);

    always_comb begin
        o_stat               = '0;
        o_stat.op            = r_op;
        o_stat.ins_bad       = (r_pos == '0) || (pos_ext > cnt_ext + 1'b1);
        o_stat.del_bad       = (r_pos == '0) || (r_pos > r_count);
        o_stat.full          = full;
        o_stat.ins_tail      = (pos_ext == cnt_ext + 1'b1);
        o_stat.del_tail      = (r_pos == r_count);
        o_stat.empty         = (r_count == '0);
        o_stat.app_refuse    = ref_now || full;
        o_stat.ptr_is_zero   = (r_ptr == '0);
        o_stat.ptr_is_cnt_m1 = (r_ptr == r_count - 1'b1);
        o_stat.ptr_is_pos_m1 = (r_ptr == r_pos - 1'b1);
        o_stat.match         = (rd_data == $unsigned(r_val));
        o_stat.out_free      = !r_out_valid || i_out_ready;
    end

    // shift writes land one slot up for insert, one slot down for delete
    assign wa_full  = (r_op == oas_pkg::OP_INSERT) ? r_ptr + 1'b1 : r_ptr - 1'b1;
    assign put_addr = (r_op == oas_pkg::OP_INSERT) ? r_pos - 1'b1 : r_count;
    assign we       = r_pend || i_cmd.put_wr;
    assign waddr    = r_pend ? r_wa : put_addr[oas_pkg::AW-1:0];
    assign wdata    = r_pend ? rd_data : $unsigned(r_val);

    oas_ram #(
        .WIDTH (oas_pkg::VAL_W),
        .DEPTH (oas_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_ptr[oas_pkg::AW-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_val   <= i_value;
            r_pos   <= i_position;
            r_first <= i_batch_first;
            r_blen  <= i_batch_length;
        end
        if (i_cmd.ptr_ld) begin
            unique case (i_cmd.ptr_src)
                oas_pkg::PTR_CNT_M1: r_ptr <= r_count - 1'b1;
                oas_pkg::PTR_POS:    r_ptr <= r_pos;
                default:             r_ptr <= '0;
            endcase
        end else if (i_cmd.ptr_step) begin
            r_ptr <= step_down ? r_ptr - 1'b1 : r_ptr + 1'b1;
        end
        r_wa <= wa_full[oas_pkg::AW-1:0];
        if (i_cmd.out_ld) begin
            r_status <= i_cmd.out_status;
            r_fpos   <= i_cmd.out_found ? r_ptr + 1'b1 : '0;
            r_rdata  <= i_cmd.out_data ? signed'(rd_data) : '0;
            r_fill   <= r_count;
            r_last   <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_refused   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.ref_upd) begin
                r_refused <= ref_now;
            end
            r_pend <= i_cmd.shift_rd;
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_found_position = r_fpos;
    assign o_read_value     = r_rdata;
    assign o_fill_count     = r_fill;
    assign o_last           = r_last;

endmodule

// ===== hdl/oas_ctrl.sv =====
// oas_ctrl: controller state machine sequencing shifts, search walks and
// read out beats over the datapath; uses oas_pkg
module oas_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  oas_pkg::t_stat i_stat,
    output oas_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_SHIFT    = 4'd2;
    localparam logic [3:0] S_DRAIN    = 4'd3;
    localparam logic [3:0] S_PUT      = 4'd4;
    localparam logic [3:0] S_SRCH_RD  = 4'd5;
    localparam logic [3:0] S_SRCH_CMP = 4'd6;
    localparam logic [3:0] S_RD_RD    = 4'd7;
    localparam logic [3:0] S_RD_OUT   = 4'd8;
    localparam logic [3:0] S_RESP     = 4'd9;

    logic [3:0]               r_state;
    logic [3:0]               n_state;
    logic [oas_pkg::ST_W-1:0] r_code;
    logic [oas_pkg::ST_W-1:0] n_code;
    logic                     r_found;
    logic                     n_found;
    logic                     is_ins;
    logic                     rd_last;

    assign is_ins     = (i_stat.op == oas_pkg::OP_INSERT);
    assign rd_last    = (i_stat.op == oas_pkg::OP_READ_REV) ? i_stat.ptr_is_zero
                                                            : i_stat.ptr_is_cnt_m1;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_code  = r_code;
        n_found = r_found;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_found = 1'b0;
                n_code  = oas_pkg::ST_OK;
                n_state = S_RESP;
                unique case (i_stat.op)
                    oas_pkg::OP_INSERT: begin
                        if (i_stat.ins_bad) begin
                            n_code = oas_pkg::ST_BADPOS;
                        end else if (i_stat.full) begin
                            n_code = oas_pkg::ST_OVERFLOW;
                        end else if (i_stat.ins_tail) begin
                            n_state = S_PUT;
                        end else begin
                            o_cmd.ptr_ld  = 1'b1;
                            o_cmd.ptr_src = oas_pkg::PTR_CNT_M1;
                            n_state       = S_SHIFT;
                        end
                    end
                    oas_pkg::OP_DELETE: begin
                        if (i_stat.del_bad) begin
                            n_code = oas_pkg::ST_BADPOS;
                        end else if (i_stat.del_tail) begin
                            o_cmd.cnt_dec = 1'b1;
                        end else begin
                            o_cmd.ptr_ld  = 1'b1;
                            o_cmd.ptr_src = oas_pkg::PTR_POS;
                            n_state       = S_SHIFT;
                        end
                    end
                    oas_pkg::OP_SEARCH: begin
                        if (i_stat.empty) begin
                            n_code = oas_pkg::ST_NOTFOUND;
                        end else begin
                            o_cmd.ptr_ld  = 1'b1;
                            o_cmd.ptr_src = oas_pkg::PTR_ZERO;
                            n_state       = S_SRCH_RD;
                        end
                    end
                    oas_pkg::OP_APPEND: begin
                        o_cmd.ref_upd = 1'b1;
                        if (i_stat.app_refuse) begin
                            n_code = oas_pkg::ST_OVERFLOW;
                        end else begin
                            o_cmd.put_wr  = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                        end
                    end
                    oas_pkg::OP_READ_FWD, oas_pkg::OP_READ_REV: begin
                        if (i_stat.empty) begin
                            n_code = oas_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.ptr_ld  = 1'b1;
                            o_cmd.ptr_src = (i_stat.op == oas_pkg::OP_READ_REV)
                                            ? oas_pkg::PTR_CNT_M1 : oas_pkg::PTR_ZERO;
                            n_state       = S_RD_RD;
                        end
                    end
                    default: begin
                        n_code = oas_pkg::ST_OK;
                    end
                endcase
            end
            S_SHIFT: begin
                o_cmd.shift_rd = 1'b1;
                if (is_ins ? i_stat.ptr_is_pos_m1 : i_stat.ptr_is_cnt_m1) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.ptr_step = 1'b1;
                end
            end
            S_DRAIN: begin
                if (is_ins) begin
                    n_state = S_PUT;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_code        = oas_pkg::ST_OK;
                    n_state       = S_RESP;
                end
            end
            S_PUT: begin
                o_cmd.put_wr  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                n_code        = oas_pkg::ST_OK;
                n_state       = S_RESP;
            end
            S_SRCH_RD: begin
                n_state = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (i_stat.match) begin
                    n_found = 1'b1;
                    n_code  = oas_pkg::ST_OK;
                    n_state = S_RESP;
                end else if (i_stat.ptr_is_cnt_m1) begin
                    n_code  = oas_pkg::ST_NOTFOUND;
                    n_state = S_RESP;
                end else begin
                    o_cmd.ptr_step = 1'b1;
                    n_state        = S_SRCH_RD;
                end
            end
            S_RD_RD: begin
                n_state = S_RD_OUT;
            end
            S_RD_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld     = 1'b1;
                    o_cmd.out_status = oas_pkg::ST_OK;
                    o_cmd.out_data   = 1'b1;
                    o_cmd.out_last   = rd_last;
                    if (rd_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.ptr_step = 1'b1;
                        n_state        = S_RD_RD;
                    end
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld     = 1'b1;
                    o_cmd.out_status = r_code;
                    o_cmd.out_found  = r_found;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= oas_pkg::ST_OK;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_found <= n_found;
        end
    end

endmodule

// ===== hdl/ordered_array_store_core.sv =====
// channel   valid        ready        payload
// input     i_in_valid   o_in_ready   i_operation i_value i_position i_batch_first
//                                     i_batch_length
// output    o_out_valid  i_out_ready  o_status o_found_position o_read_value
//                                     o_fill_count o_last
//
// one item at a time; every beat goes through a single result register
// insert and delete shift every entry past the position by one slot; a tail position needs no shift
// search reads and compares one entry at a time from the bottom; append and bad positions need no walk
// read out: each beat waits on the registered read of the element ram
// synchronous active-low reset clears count and batch flag, no ram clearing pass
// output stalls hold the walk; the next item is taken while the last beat waits
//
// top level: ordered store with insert, delete, search, batch append, read out
// depends on oas_pkg, oas_ctrl, oas_dp, oas_ram
module ordered_array_store_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [oas_pkg::OP_W-1:0]          i_operation,
    input  logic signed [oas_pkg::VAL_W-1:0]  i_value,
    input  logic [oas_pkg::POS_W-1:0]         i_position,
    input  logic                              i_batch_first,
    input  logic [oas_pkg::CNT_W-1:0]         i_batch_length,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [oas_pkg::ST_W-1:0]          o_status,
    output logic [oas_pkg::POS_W-1:0]         o_found_position,
    output logic signed [oas_pkg::VAL_W-1:0]  o_read_value,
    output logic [oas_pkg::CNT_W-1:0]         o_fill_count,
    output logic                              o_last
);

    oas_pkg::t_cmd  cmd;
    oas_pkg::t_stat stat;

    oas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    oas_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_operation      (i_operation),
        .i_value          (i_value),
        .i_position       (i_position),
        .i_batch_first    (i_batch_first),
        .i_batch_length   (i_batch_length),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_read_value     (o_read_value),
        .o_fill_count     (o_fill_count),
        .o_last           (o_last)
    );

endmodule

// ===== hdl/oas_checker.sv =====
// oas_checker: port-level checks on the top level, attached by bind
// depends on oas_pkg and ordered_array_store_core
module oas_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic [oas_pkg::OP_W-1:0]          i_operation,
    input logic signed [oas_pkg::VAL_W-1:0]  i_value,
    input logic [oas_pkg::POS_W-1:0]         i_position,
    input logic                              i_batch_first,
    input logic [oas_pkg::CNT_W-1:0]         i_batch_length,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [oas_pkg::ST_W-1:0]          o_status,
    input logic [oas_pkg::POS_W-1:0]         o_found_position,
    input logic signed [oas_pkg::VAL_W-1:0]  o_read_value,
    input logic [oas_pkg::CNT_W-1:0]         o_fill_count,
    input logic                              o_last
);

    // an accepted item closes the input side in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted on consecutive cycles");

    // a stalled beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_status) && $stable(o_read_value) && $stable(o_last)))
        else $error("stalled result beat changed");

    // fill count never exceeds the store size
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fill_count <= oas_pkg::CNT_W'(oas_pkg::DEPTH)))
        else $error("fill count beyond store size");

    // any failure is a single, final beat with no data
    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != oas_pkg::ST_OK)) |->
            (o_last && (o_read_value == '0) && (o_found_position == '0)))
        else $error("failure result not a lone beat");

endmodule

bind ordered_array_store_core oas_checker u_oas_checker (.*);
